// ===== sv/ttcf_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcf_pkg
// shared types and constants of the threshold transition crossfade block
// ----------------------------------------------------------------------------
package ttcf_pkg;

  // fixed point layout of the blend weights
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WGT_W     = FRAC_BITS + 1;
  localparam logic [WGT_W-1:0] WGT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // command codes
  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_SET_PARAM   = 3'd1,
    ACT_WRITE_SLOT  = 3'd2,
    ACT_SET_ENTRY   = 3'd3,
    ACT_ADD_STATE   = 3'd4
  } act_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLIP,
    ST_FADE,
    ST_DIV_GO,
    ST_DIV
  } seq_state_e;

  // input word
  typedef struct packed {
    logic        [2:0]  action;
    logic        [31:0] delta_time;
    logic        [3:0]  param_index;
    logic signed [31:0] param_value;
    logic        [3:0]  slot_index;
    logic        [4:0]  source_state;
    logic        [4:0]  target_state;
    logic        [3:0]  cond_param;
    logic signed [31:0] threshold;
    logic        [31:0] fade_length;
    logic        [4:0]  state_id;
  } cmd_t;

  // result word
  typedef struct packed {
    logic [4:0]       current_id;
    logic [4:0]       previous_id;
    logic [31:0]      clip_elapsed;
    logic [31:0]      fade_elapsed_out;
    logic [31:0]      fade_duration_out;
    logic [WGT_W-1:0] weight_current;
    logic [WGT_W-1:0] weight_previous;
    logic [WGT_W-1:0] queried_weight;
    logic             transitioned;
  } res_t;

  // one transition slot entry
  typedef struct packed {
    logic        [4:0]  source;
    logic        [4:0]  target;
    logic        [3:0]  param;
    logic signed [31:0] threshold;
    logic        [31:0] fade;
  } slot_t;

  // read side of the table store
  typedef struct packed {
    logic               cur_present;
    logic               slot_valid;
    slot_t              slot;
    logic signed [31:0] param;
  } store_rd_t;

  // divider status
  typedef struct packed {
    logic             done;
    logic [WGT_W-1:0] quo;
  } div_res_t;

endpackage

// ===== sv/ttcf_store.sv =====
// ----------------------------------------------------------------------------
// ttcf_store
// state presence bits, parameter memory and transition slot memory
// ----------------------------------------------------------------------------
module ttcf_store
  import ttcf_pkg::*;
#(
  parameter int unsigned NUM_STATES = 32,
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned NUM_PARAMS = 16,
  localparam int unsigned ST_AW   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1,
  localparam int unsigned SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  cmd_t               cmd_i,
  input  logic [4:0]         cur_id_i,
  input  logic               slot_re_i,
  input  logic [SLOT_AW-1:0] slot_raddr_i,
  input  logic               par_re_i,
  input  logic [3:0]         par_ridx_i,
  output store_rd_t          rd_o
);

  localparam int unsigned PAR_AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

  logic [NUM_STATES-1:0] present_q;
  logic [NUM_SLOTS-1:0]  slot_vld_q;
  logic [NUM_PARAMS-1:0] par_vld_q;

  slot_t              slot_mem [NUM_SLOTS];
  logic signed [31:0] par_mem  [NUM_PARAMS];

  slot_t              slot_rd_q;
  logic               slot_rd_vld_q;
  logic signed [31:0] par_rd_q;
  logic               par_rd_ok_q;

  logic state_in, slot_in, par_in, cur_in, ridx_in;

  assign state_in = 32'(cmd_i.state_id) < 32'(NUM_STATES);
  assign slot_in  = 32'(cmd_i.slot_index) < 32'(NUM_SLOTS);
  assign par_in   = 32'(cmd_i.param_index) < 32'(NUM_PARAMS);
  assign cur_in   = 32'(cur_id_i) < 32'(NUM_STATES);
  assign ridx_in  = 32'(par_ridx_i) < 32'(NUM_PARAMS);

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q     <= '0;
      slot_vld_q    <= '0;
      par_vld_q     <= '0;
      slot_rd_vld_q <= 1'b0;
      par_rd_ok_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        case (cmd_i.action)
          ACT_ADD_STATE:  if (state_in) present_q[ST_AW'(cmd_i.state_id)] <= 1'b1;
          ACT_WRITE_SLOT: if (slot_in) slot_vld_q[SLOT_AW'(cmd_i.slot_index)] <= 1'b1;
          ACT_SET_PARAM:  if (par_in) par_vld_q[PAR_AW'(cmd_i.param_index)] <= 1'b1;
          default: ;
        endcase
      end
      if (slot_re_i) slot_rd_vld_q <= slot_vld_q[slot_raddr_i];
      if (par_re_i)  par_rd_ok_q <= ridx_in && par_vld_q[PAR_AW'(par_ridx_i)];
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (cmd_i.action == ACT_WRITE_SLOT) && slot_in) begin
      slot_mem[SLOT_AW'(cmd_i.slot_index)] <= '{source:    cmd_i.source_state,
                                                target:    cmd_i.target_state,
                                                param:     cmd_i.cond_param,
                                                threshold: cmd_i.threshold,
                                                fade:      cmd_i.fade_length};
    end
    if (slot_re_i) slot_rd_q <= slot_mem[slot_raddr_i];
  end

  // parameter memory
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (cmd_i.action == ACT_SET_PARAM) && par_in) begin
      par_mem[PAR_AW'(cmd_i.param_index)] <= cmd_i.param_value;
    end
    if (par_re_i) par_rd_q <= par_mem[PAR_AW'(par_ridx_i)];
  end

  assign rd_o.cur_present = cur_in && present_q[ST_AW'(cur_id_i)];
  assign rd_o.slot_valid  = slot_rd_vld_q;
  assign rd_o.slot        = slot_rd_q;
  assign rd_o.param       = par_rd_ok_q ? par_rd_q : 32'sd0;

endmodule

// ===== sv/ttcf_div.sv =====
// ----------------------------------------------------------------------------
// ttcf_div
// restoring divider for the blend weight, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ttcf_div
  import ttcf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,   // elapsed fade time, never above den_i
  input  logic [31:0] den_i,
  output div_res_t    res_o
);

  localparam int unsigned CNT_W = $clog2(WGT_W + 1);

  logic [32:0]      rem_q, rem_d;
  logic [31:0]      den_q, den_d;
  logic [WGT_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;

  logic        ge;
  logic [32:0] diff, nrem;

  // remainder starts as the numerator, the fraction zeros are shifted in
  assign ge   = rem_q >= {1'b0, den_q};
  assign diff = rem_q - {1'b0, den_q};
  assign nrem = ge ? diff : rem_q;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = {1'b0, num_i};
      den_d = den_i;
      quo_d = '0;
      cnt_d = CNT_W'(WGT_W);
    end else if (cnt_q != '0) begin
      rem_d  = {nrem[31:0], 1'b0};
      quo_d  = {quo_q[WGT_W-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign res_o.done = done_q;
  assign res_o.quo  = quo_q;

endmodule

// ===== sv/threshold_transition_crossfade_fsm.sv =====
// ----------------------------------------------------------------------------
// threshold_transition_crossfade_fsm
// table-driven state graph with threshold transitions and a timed crossfade
// ----------------------------------------------------------------------------
//  channel   ports                      dir  word
//  command   start busy cmd_i           in   cmd_t, taken when start && !busy
//  result    res_valid_o res_o          out  res_t, one-cycle strobe, no stall
//
//  a tick runs from accept to result strobe through these steps: the slot
//  scan reads one slot a cycle through the slot and parameter memory ports
//  (stopping early on a hit, none when the current state was never added),
//  the clip and fade timer update states, the divider load state, then the
//  serial divider at one quotient bit a cycle (FRAC_BITS + 1 steps, its
//  registered done flag ends it); other commands go straight to the divider load. busy
//  drops in the cycle the result strobe shows, so the next word can be taken
//  right then. reset clears all valid bits at once; no clearing pass. the
//  result side cannot stall.
// ----------------------------------------------------------------------------
module threshold_transition_crossfade_fsm
  import ttcf_pkg::*;
#(
  parameter int unsigned NUM_STATES = 32,
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned NUM_PARAMS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned SLOT_CW = $clog2(NUM_SLOTS + 1);

  seq_state_e state_q, state_d;

  // architectural state
  logic [4:0]  cur_q, cur_d;
  logic [4:0]  prev_q, prev_d;
  logic [31:0] clip_q, clip_d;
  logic [31:0] fade_q, fade_d;
  logic [31:0] dur_q, dur_d;

  // per-word working registers
  logic [31:0] dt_q, dt_d;
  logic [4:0]  sid_q, sid_d;
  logic        taken_q, taken_d;

  // scan pipeline: issue counter, memory read stage, compare stage
  logic [SLOT_CW-1:0] issue_q, issue_d;
  logic               s1_v_q, s1_v_d;
  logic               s2_v_q, s2_v_d;
  logic               s2_cand_q, s2_cand_d;
  slot_t              s2_slot_q, s2_slot_d;

  logic res_valid_q, res_valid_d;
  res_t res_q, res_d;

  logic      accept;
  logic      issue_go, hit, scan_end;
  logic      slot_re, par_re, div_start;
  store_rd_t rd;
  div_res_t  div;

  logic [32:0]      clip_sum, fade_sum;
  logic [31:0]      fade_clamped;
  logic [WGT_W-1:0] w_cur, w_prev, w_q;

  assign accept = start && !busy;

  ttcf_store #(
    .NUM_STATES (NUM_STATES),
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_PARAMS (NUM_PARAMS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (accept),
    .cmd_i        (cmd_i),
    .cur_id_i     (cur_q),
    .slot_re_i    (slot_re),
    .slot_raddr_i (issue_q[SLOT_AW-1:0]),
    .par_re_i     (par_re),
    .par_ridx_i   (rd.slot.param),
    .rd_o         (rd)
  );

  ttcf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (fade_clamped),
    .den_i   (dur_q),
    .res_o   (div)
  );

  // scan control: slots come out of the compare stage in slot order, so the
  // first hit seen is the highest priority one
  assign issue_go = issue_q != SLOT_CW'(NUM_SLOTS);
  assign hit      = s2_v_q && s2_cand_q && (rd.param >= s2_slot_q.threshold);
  assign scan_end = !issue_go && !s1_v_q && !s2_v_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i.action == ACT_TICK) begin
            state_d = rd.cur_present ? ST_SCAN : ST_CLIP;
          end else begin
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_SCAN:   if (hit || scan_end) state_d = ST_CLIP;
      ST_CLIP:   state_d = ST_FADE;
      ST_FADE:   state_d = ST_DIV_GO;
      ST_DIV_GO: state_d = ST_DIV;
      ST_DIV:    if (div.done) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy      = 1'b1;
    slot_re   = 1'b0;
    par_re    = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE:   busy = 1'b0;
      ST_SCAN: begin
        slot_re = issue_go && !hit;
        par_re  = s1_v_q;
      end
      ST_DIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  // timer arithmetic
  assign clip_sum     = {1'b0, clip_q} + {1'b0, dt_q};
  assign fade_sum     = {1'b0, fade_q} + {1'b0, dt_q};
  assign fade_clamped = (fade_q > dur_q) ? dur_q : fade_q;

  // blend weights from the divider quotient
  assign w_cur  = (dur_q == '0) ? WGT_ONE : div.quo;
  assign w_prev = WGT_ONE - w_cur;
  always_comb begin
    if (sid_q == cur_q) begin
      w_q = w_cur;
    end else if (sid_q == prev_q) begin
      w_q = w_prev;
    end else begin
      w_q = '0;
    end
  end

  // datapath
  always_comb begin
    cur_d       = cur_q;
    prev_d      = prev_q;
    clip_d      = clip_q;
    fade_d      = fade_q;
    dur_d       = dur_q;
    dt_d        = dt_q;
    sid_d       = sid_q;
    taken_d     = taken_q;
    issue_d     = issue_q;
    s1_v_d      = 1'b0;
    s2_v_d      = 1'b0;
    s2_cand_d   = s2_cand_q;
    s2_slot_d   = s2_slot_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          dt_d    = cmd_i.delta_time;
          sid_d   = cmd_i.state_id;
          taken_d = 1'b0;
          issue_d = '0;
          if (cmd_i.action == ACT_SET_ENTRY) cur_d = cmd_i.state_id;
        end
      end
      ST_SCAN: begin
        if (slot_re) begin
          issue_d = issue_q + SLOT_CW'(1);
          s1_v_d  = 1'b1;
        end
        // stage one: slot word is back, parameter read goes out
        s2_v_d    = s1_v_q && !hit;
        s2_slot_d = rd.slot;
        s2_cand_d = rd.slot_valid && (rd.slot.source == cur_q);
        // stage two: take the transition
        if (hit) begin
          prev_d  = cur_q;
          cur_d   = s2_slot_q.target;
          fade_d  = '0;
          dur_d   = s2_slot_q.fade;
          clip_d  = '0;
          taken_d = 1'b1;
          s1_v_d  = 1'b0;
        end
      end
      ST_CLIP: begin
        // saturating clip timer
        clip_d = clip_sum[32] ? '1 : clip_sum[31:0];
      end
      ST_FADE: begin
        // fade timer clamps at its duration
        if (dur_q != '0) begin
          fade_d = (fade_sum > {1'b0, dur_q}) ? dur_q : fade_sum[31:0];
        end
      end
      ST_DIV: begin
        if (div.done) begin
          res_valid_d             = 1'b1;
          res_d.current_id        = cur_q;
          res_d.previous_id       = prev_q;
          res_d.clip_elapsed      = clip_q;
          res_d.fade_elapsed_out  = fade_q;
          res_d.fade_duration_out = dur_q;
          res_d.weight_current    = w_cur;
          res_d.weight_previous   = w_prev;
          res_d.queried_weight    = w_q;
          res_d.transitioned      = taken_q;
        end
      end
      default: ;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      prev_q      <= '0;
      clip_q      <= '0;
      fade_q      <= '0;
      dur_q       <= '0;
      issue_q     <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      clip_q      <= clip_d;
      fade_q      <= fade_d;
      dur_q       <= dur_d;
      issue_q     <= issue_d;
      s1_v_q      <= s1_v_d;
      s2_v_q      <= s2_v_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    dt_q      <= dt_d;
    sid_q     <= sid_d;
    taken_q   <= taken_d;
    s2_cand_q <= s2_cand_d;
    s2_slot_q <= s2_slot_d;
    res_q     <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // result strobe lasts one cycle, no two results back to back
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  // a taken word keeps the block busy until its result
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !res_valid_o))
    else $error("block not busy after accepting a word");

  // no fade means full weight on the current state
  a_no_fade_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.fade_duration_out == '0)) |->
      ((res_o.weight_current == WGT_ONE) && (res_o.weight_previous == '0)))
    else $error("weights wrong without a fade");

  // fade timer never runs past its duration
  a_fade_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.fade_elapsed_out <= res_o.fade_duration_out))
    else $error("fade timer past its duration");
`endif

endmodule
